[hdl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define NSH_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled in reset.
`define NSH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

[hdl/nsh_pkg.sv]
// Shared types, constants and angle table for the nearest segment heading block.
package nsh_pkg;

   localparam int COORD_BITS_DEF   = 32;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int QUEUE_DEPTH      = 2;
   localparam int DIST_BITS        = 64;
   localparam int HEAD_BITS        = 16;
   localparam int ANGLE_BITS       = 32;
   localparam int VEC_BITS         = 64;
   localparam int NORM_TOP         = 58;
   localparam int NORM_STEPS       = 6;
   localparam int HEAD_MAX         = 23040;
   localparam int HALF_TURN        = 180 * 65536;
   localparam int ROUND_HALF       = 256;
   localparam int Q7_SHIFT         = 9;

   // coordinate slots of one item
   localparam int COORD_SLOTS = 6;
   localparam int CI_AX = 0;
   localparam int CI_AY = 1;
   localparam int CI_BX = 2;
   localparam int CI_BY = 3;
   localparam int CI_QX = 4;
   localparam int CI_QY = 5;

   // accumulator slots
   localparam int ACC_COUNT = 5;
   localparam logic [2:0] ACC_T    = 3'd0;
   localparam logic [2:0] ACC_D    = 3'd1;
   localparam logic [2:0] ACC_A    = 3'd2;
   localparam logic [2:0] ACC_B    = 3'd3;
   localparam logic [2:0] ACC_DIST = 3'd4;

   typedef enum logic {
      KIND_SKIP,
      KIND_SEG
   } kind_type;

   typedef struct packed {
      kind_type kind;
      logic     last;
   } ctl_type;

   // product sequence; pairs share one accumulator slot (step >> 1)
   typedef enum logic [3:0] {
      MS_TX, MS_TY, MS_DX, MS_DY, MS_AX, MS_AY, MS_BX, MS_BY, MS_FX, MS_FY
   } mul_step_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_MUL, BK_MACC, BK_DECIDE, BK_DIV, BK_FOOT, BK_UPD, BK_FINISH
   } back_state_type;

   typedef enum logic [1:0] {
      CR_IDLE, CR_NORM, CR_ITER, CR_DONE
   } cordic_state_type;

   function automatic logic signed [ANGLE_BITS-1:0] atan_q16(input logic [4:0] idx);
      logic signed [ANGLE_BITS-1:0] v;
      case (idx)
         5'd0:    v = 32'sd2949120;
         5'd1:    v = 32'sd1740967;
         5'd2:    v = 32'sd919879;
         5'd3:    v = 32'sd466945;
         5'd4:    v = 32'sd234379;
         5'd5:    v = 32'sd117304;
         5'd6:    v = 32'sd58666;
         5'd7:    v = 32'sd29335;
         5'd8:    v = 32'sd14668;
         5'd9:    v = 32'sd7334;
         5'd10:   v = 32'sd3667;
         5'd11:   v = 32'sd1833;
         5'd12:   v = 32'sd917;
         5'd13:   v = 32'sd458;
         5'd14:   v = 32'sd229;
         5'd15:   v = 32'sd115;
         5'd16:   v = 32'sd57;
         5'd17:   v = 32'sd29;
         5'd18:   v = 32'sd14;
         5'd19:   v = 32'sd7;
         5'd20:   v = 32'sd4;
         5'd21:   v = 32'sd2;
         5'd22:   v = 32'sd1;
         default: v = 32'sd0;
      endcase
      return v;
   endfunction

endpackage

[hdl/nearest_segment_heading_core.sv]
// Top level: front queue, geometry back end, bearing unit and result register.
//
//   channel | role   | moves per transfer
//   req_    | input  | one segment with query point, seg_valid, last_item
//   rsp_    | output | heading, found flag, squared distance (one per search)
//
// A segment takes longer when the foot point is used than when an endpoint is
// nearest; the restoring divider (one bit per cycle, both axes side by side)
// accounts for the difference.
// The bearing computation overlaps the next search.
// Synchronous reset clears control state; no clearing pass is needed.
// The two-entry input queue and the result register let either side stall.
module nearest_segment_heading_core #(
   parameter int COORD_BITS   = nsh_pkg::COORD_BITS_DEF,
   parameter int CORDIC_STEPS = nsh_pkg::CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_seg_a_x,
   input  logic [COORD_BITS-1:0] req_seg_a_y,
   input  logic [COORD_BITS-1:0] req_seg_b_x,
   input  logic [COORD_BITS-1:0] req_seg_b_y,
   input  logic [COORD_BITS-1:0] req_query_x,
   input  logic [COORD_BITS-1:0] req_query_y,
   input  logic                  req_seg_valid,
   input  logic                  req_last_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [nsh_pkg::HEAD_BITS-1:0] rsp_heading_deg,
   output logic                  rsp_found,
   output logic [nsh_pkg::DIST_BITS-1:0] rsp_best_dist_sq
);

   logic                  q_valid, q_pop;
   logic [nsh_pkg::COORD_SLOTS-1:0][COORD_BITS-1:0] q_coord;
   nsh_pkg::ctl_type      q_ctl;
   logic                  job_valid, job_ready, job_found;
   logic signed [COORD_BITS+1:0] job_dx, job_dy;
   logic [nsh_pkg::DIST_BITS-1:0] job_dist, out_dist;
   logic                  out_free, out_load, out_found;
   logic [nsh_pkg::HEAD_BITS-1:0] out_heading;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [nsh_pkg::HEAD_BITS-1:0] heading_ff;
   logic                  found_ff;
   logic [nsh_pkg::DIST_BITS-1:0] dist_ff;

   nsh_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .req_valid, .req_ready,
      .req_seg_a_x, .req_seg_a_y, .req_seg_b_x, .req_seg_b_y,
      .req_query_x, .req_query_y, .req_seg_valid, .req_last_item,
      .q_valid, .q_pop, .q_coord, .q_ctl
   );

   nsh_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_coord, .q_ctl,
      .job_valid, .job_ready, .job_dx, .job_dy, .job_found, .job_dist
   );

   nsh_cordic #(.COORD_BITS(COORD_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock, .reset, .job_valid, .job_ready, .job_dx, .job_dy, .job_found, .job_dist,
      .out_free, .out_load, .out_heading, .out_found, .out_dist
   );

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_heading_deg  = heading_ff;
   assign rsp_found        = found_ff;
   assign rsp_best_dist_sq = dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         heading_ff <= out_heading;
         found_ff   <= out_found;
         dist_ff    <= out_dist;
      end
   end

endmodule

[hdl/nsh_front.sv]
// Input side: accepts items, tags degenerate segments and queues them for the back end.
module nsh_front #(
   parameter int COORD_BITS = nsh_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [COORD_BITS-1:0] req_seg_a_x,
   input  logic [COORD_BITS-1:0] req_seg_a_y,
   input  logic [COORD_BITS-1:0] req_seg_b_x,
   input  logic [COORD_BITS-1:0] req_seg_b_y,
   input  logic [COORD_BITS-1:0] req_query_x,
   input  logic [COORD_BITS-1:0] req_query_y,
   input  logic                  req_seg_valid,
   input  logic                  req_last_item,
   output logic                  q_valid,
   input  logic                  q_pop,
   output logic [nsh_pkg::COORD_SLOTS-1:0][COORD_BITS-1:0] q_coord,
   output nsh_pkg::ctl_type      q_ctl
);

   localparam int PW = $clog2(nsh_pkg::QUEUE_DEPTH);

   logic [nsh_pkg::COORD_SLOTS-1:0][COORD_BITS-1:0] coord_ff [nsh_pkg::QUEUE_DEPTH];
   nsh_pkg::ctl_type ctl_ff [nsh_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;
   logic          push;
   logic          degenerate;
   nsh_pkg::ctl_type new_ctl;

   assign req_ready  = (count_ff != (PW+1)'(nsh_pkg::QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign degenerate = (req_seg_a_x == req_seg_b_x) && (req_seg_a_y == req_seg_b_y);
   assign q_valid    = (count_ff != '0);
   assign q_coord    = coord_ff[rd_ptr_ff];
   assign q_ctl      = ctl_ff[rd_ptr_ff];

   always_comb begin
      new_ctl.kind = (req_seg_valid && !degenerate) ? nsh_pkg::KIND_SEG : nsh_pkg::KIND_SKIP;
      new_ctl.last = req_last_item;
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         coord_ff[wr_ptr_ff][nsh_pkg::CI_AX] <= req_seg_a_x;
         coord_ff[wr_ptr_ff][nsh_pkg::CI_AY] <= req_seg_a_y;
         coord_ff[wr_ptr_ff][nsh_pkg::CI_BX] <= req_seg_b_x;
         coord_ff[wr_ptr_ff][nsh_pkg::CI_BY] <= req_seg_b_y;
         coord_ff[wr_ptr_ff][nsh_pkg::CI_QX] <= req_query_x;
         coord_ff[wr_ptr_ff][nsh_pkg::CI_QY] <= req_query_y;
         ctl_ff[wr_ptr_ff] <= new_ctl;
      end
   end

endmodule

[hdl/nsh_back.sv]
// Geometry sequencer: products, foot-point division, running minimum, search close.
module nsh_back #(
   parameter int COORD_BITS = nsh_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  logic [nsh_pkg::COORD_SLOTS-1:0][COORD_BITS-1:0] q_coord,
   input  nsh_pkg::ctl_type      q_ctl,
   output logic                  job_valid,
   input  logic                  job_ready,
   output logic signed [COORD_BITS+1:0] job_dx,
   output logic signed [COORD_BITS+1:0] job_dy,
   output logic                  job_found,
   output logic [nsh_pkg::DIST_BITS-1:0] job_dist
);

   localparam int N  = COORD_BITS;
   localparam int D1 = N + 1;
   localparam int D2 = N + 2;
   localparam int PB = 2 * D2;
   localparam int SW = PB + 1;
   localparam int CW = $clog2(D1 + 1);
   localparam int DB = nsh_pkg::DIST_BITS;

   nsh_pkg::back_state_type state_ff, state_in;
   nsh_pkg::mul_step_type   step_ff, step_in, ptag_ff, ptag_in;
   logic                    pvld_ff, pvld_in;
   logic                    last_ff, last_in;
   logic [CW-1:0]           cnt_ff, cnt_in;

   logic signed [D1-1:0] ex_ff, ey_ff, ux_ff, uy_ff, ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [D1-1:0] ex_in, ey_in, ux_in, uy_in, ax_in, ay_in, bx_in, by_in;
   logic signed [D2-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [PB-1:0] prod_ff, prod_in;
   logic signed [SW-1:0] acc_ff [nsh_pkg::ACC_COUNT];
   logic signed [SW-1:0] acc_wr;
   logic [2:0]           acc_sel;

   logic [SW-1:0] rem_ff [2];
   logic [SW-1:0] rem_in [2];
   logic [D1-1:0] quo_ff [2];
   logic [D1-1:0] quo_in [2];
   logic [D1-1:0] mag_ff [2];
   logic [D1-1:0] mag_in [2];

   logic [DB-1:0]        best_dist_ff, best_dist_in;
   logic signed [D2-1:0] best_dx_ff, best_dx_in, best_dy_ff, best_dy_in;
   logic                 found_ff, found_in;

   logic signed [D2-1:0] opa, opb;
   logic signed [D1-1:0] cax, cay, cbx, cby, cqx, cqy;
   logic signed [SW-1:0] t_val, d_val;
   logic [SW-1:0]        tu, du, du2, r2, rr;
   logic [D1-1:0]        qr;
   logic signed [D2-1:0] foot [2];
   logic [DB+SW-1:0]     dist_ext;
   logic [DB-1:0]        dist_sat;

   assign cax = {q_coord[nsh_pkg::CI_AX][N-1], q_coord[nsh_pkg::CI_AX]};
   assign cay = {q_coord[nsh_pkg::CI_AY][N-1], q_coord[nsh_pkg::CI_AY]};
   assign cbx = {q_coord[nsh_pkg::CI_BX][N-1], q_coord[nsh_pkg::CI_BX]};
   assign cby = {q_coord[nsh_pkg::CI_BY][N-1], q_coord[nsh_pkg::CI_BY]};
   assign cqx = {q_coord[nsh_pkg::CI_QX][N-1], q_coord[nsh_pkg::CI_QX]};
   assign cqy = {q_coord[nsh_pkg::CI_QY][N-1], q_coord[nsh_pkg::CI_QY]};

   assign t_val = acc_ff[nsh_pkg::ACC_T];
   assign d_val = acc_ff[nsh_pkg::ACC_D];
   assign tu    = t_val;
   assign du    = d_val;
   assign du2   = du << 1;

   assign dist_ext = {{DB{1'b0}}, acc_ff[nsh_pkg::ACC_DIST]};
   assign dist_sat = (|dist_ext[DB+SW-1:DB]) ? {DB{1'b1}} : dist_ext[DB-1:0];

   assign acc_sel = ptag_ff[3:1];
   assign acc_wr  = ptag_ff[0] ? acc_ff[acc_sel] + {prod_ff[PB-1], prod_ff}
                               : {prod_ff[PB-1], prod_ff};

   assign job_dx    = best_dx_ff;
   assign job_dy    = best_dy_ff;
   assign job_found = found_ff;
   assign job_dist  = best_dist_ff;

   always_comb begin
      case (step_ff)
         nsh_pkg::MS_TX: begin opa = D2'(ux_ff); opb = D2'(ex_ff); end
         nsh_pkg::MS_TY: begin opa = D2'(uy_ff); opb = D2'(ey_ff); end
         nsh_pkg::MS_DX: begin opa = D2'(ex_ff); opb = D2'(ex_ff); end
         nsh_pkg::MS_DY: begin opa = D2'(ey_ff); opb = D2'(ey_ff); end
         nsh_pkg::MS_AX: begin opa = D2'(ax_ff); opb = D2'(ax_ff); end
         nsh_pkg::MS_AY: begin opa = D2'(ay_ff); opb = D2'(ay_ff); end
         nsh_pkg::MS_BX: begin opa = D2'(bx_ff); opb = D2'(bx_ff); end
         nsh_pkg::MS_BY: begin opa = D2'(by_ff); opb = D2'(by_ff); end
         nsh_pkg::MS_FX: begin opa = dx_ff; opb = dx_ff; end
         nsh_pkg::MS_FY: begin opa = dy_ff; opb = dy_ff; end
         default:        begin opa = '0; opb = '0; end
      endcase
   end

   // one restoring step per lane: quotient digit 0, 1 or 2
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         r2 = (rem_ff[k] << 1) + (mag_ff[k][D1-1] ? tu : '0);
         if (r2 >= du2) begin
            rem_in[k] = r2 - du2;
            quo_in[k] = (quo_ff[k] << 1) + D1'(2);
         end else if (r2 >= du) begin
            rem_in[k] = r2 - du;
            quo_in[k] = (quo_ff[k] << 1) + D1'(1);
         end else begin
            rem_in[k] = r2;
            quo_in[k] = quo_ff[k] << 1;
         end
         mag_in[k] = mag_ff[k] << 1;
      end
   end

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         rr = rem_ff[k] << 1;
         qr = quo_ff[k] + ((rr >= du) ? D1'(1) : D1'(0));
         foot[k] = (k == 0 ? ex_ff[D1-1] : ey_ff[D1-1]) ? -$signed({1'b0, qr})
                                                        : $signed({1'b0, qr});
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ptag_in      = ptag_ff;
      pvld_in      = 1'b0;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      ex_in = ex_ff; ey_in = ey_ff; ux_in = ux_ff; uy_in = uy_ff;
      ax_in = ax_ff; ay_in = ay_ff; bx_in = bx_ff; by_in = by_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      best_dist_in = best_dist_ff;
      best_dx_in   = best_dx_ff;
      best_dy_in   = best_dy_ff;
      found_in     = found_ff;
      q_pop        = 1'b0;
      job_valid    = 1'b0;
      case (state_ff)
         nsh_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               last_in = q_ctl.last;
               ex_in = cbx - cax; ey_in = cby - cay;
               ux_in = cqx - cax; uy_in = cqy - cay;
               ax_in = cax - cqx; ay_in = cay - cqy;
               bx_in = cbx - cqx; by_in = cby - cqy;
               step_in = nsh_pkg::MS_TX;
               if (q_ctl.kind == nsh_pkg::KIND_SEG) begin
                  state_in = nsh_pkg::BK_MUL;
               end else if (q_ctl.last) begin
                  state_in = nsh_pkg::BK_FINISH;
               end
            end
         end
         nsh_pkg::BK_MUL: begin
            prod_in = opa * opb;
            ptag_in = step_ff;
            pvld_in = 1'b1;
            if (step_ff == nsh_pkg::MS_BY || step_ff == nsh_pkg::MS_FY) begin
               state_in = nsh_pkg::BK_MACC;
            end else begin
               step_in = nsh_pkg::mul_step_type'(step_ff + 4'd1);
            end
         end
         nsh_pkg::BK_MACC: begin
            state_in = (ptag_ff == nsh_pkg::MS_BY) ? nsh_pkg::BK_DECIDE : nsh_pkg::BK_UPD;
         end
         nsh_pkg::BK_DECIDE: begin
            step_in = nsh_pkg::MS_FX;
            if (d_val == '0) begin
               state_in = last_ff ? nsh_pkg::BK_FINISH : nsh_pkg::BK_IDLE;
            end else if (!t_val[SW-1] && !(d_val < t_val)) begin
               cnt_in   = CW'(D1);
               state_in = nsh_pkg::BK_DIV;
            end else begin
               if (acc_ff[nsh_pkg::ACC_A] < acc_ff[nsh_pkg::ACC_B]) begin
                  dx_in = D2'(ax_ff);
                  dy_in = D2'(ay_ff);
               end else begin
                  dx_in = D2'(bx_ff);
                  dy_in = D2'(by_ff);
               end
               state_in = nsh_pkg::BK_MUL;
            end
         end
         nsh_pkg::BK_DIV: begin
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = nsh_pkg::BK_FOOT;
            end
         end
         nsh_pkg::BK_FOOT: begin
            dx_in    = D2'(ax_ff) + foot[0];
            dy_in    = D2'(ay_ff) + foot[1];
            state_in = nsh_pkg::BK_MUL;
         end
         nsh_pkg::BK_UPD: begin
            if (!found_ff || dist_sat < best_dist_ff) begin
               best_dist_in = dist_sat;
               best_dx_in   = dx_ff;
               best_dy_in   = dy_ff;
               found_in     = 1'b1;
            end
            state_in = last_ff ? nsh_pkg::BK_FINISH : nsh_pkg::BK_IDLE;
         end
         nsh_pkg::BK_FINISH: begin
            job_valid = 1'b1;
            if (job_ready) begin
               best_dist_in = '1;
               best_dx_in   = '0;
               best_dy_in   = '0;
               found_in     = 1'b0;
               state_in     = nsh_pkg::BK_IDLE;
            end
         end
         default: state_in = nsh_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nsh_pkg::BK_IDLE;
         pvld_ff      <= 1'b0;
         best_dist_ff <= '1;
         best_dx_ff   <= '0;
         best_dy_ff   <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pvld_ff      <= pvld_in;
         best_dist_ff <= best_dist_in;
         best_dx_ff   <= best_dx_in;
         best_dy_ff   <= best_dy_in;
         found_ff     <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      ptag_ff <= ptag_in;
      last_ff <= last_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
      ex_ff <= ex_in; ey_ff <= ey_in; ux_ff <= ux_in; uy_ff <= uy_in;
      ax_ff <= ax_in; ay_ff <= ay_in; bx_ff <= bx_in; by_ff <= by_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      if (pvld_ff) begin
         acc_ff[acc_sel] <= acc_wr;
      end
      if (state_ff == nsh_pkg::BK_DECIDE) begin
         rem_ff[0] <= '0;
         rem_ff[1] <= '0;
         quo_ff[0] <= '0;
         quo_ff[1] <= '0;
         mag_ff[0] <= ex_ff[D1-1] ? D1'(-ex_ff) : D1'(ex_ff);
         mag_ff[1] <= ey_ff[D1-1] ? D1'(-ey_ff) : D1'(ey_ff);
      end else if (state_ff == nsh_pkg::BK_DIV) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         mag_ff <= mag_in;
      end
   end

endmodule

[hdl/nsh_cordic.sv]
// Bearing unit: half-turn fold, binary normalization, CORDIC vectoring, Q9.7 rounding.
module nsh_cordic #(
   parameter int COORD_BITS   = nsh_pkg::COORD_BITS_DEF,
   parameter int CORDIC_STEPS = nsh_pkg::CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  logic signed [COORD_BITS+1:0] job_dx,
   input  logic signed [COORD_BITS+1:0] job_dy,
   input  logic                  job_found,
   input  logic [nsh_pkg::DIST_BITS-1:0] job_dist,
   input  logic                  out_free,
   output logic                  out_load,
   output logic [nsh_pkg::HEAD_BITS-1:0] out_heading,
   output logic                  out_found,
   output logic [nsh_pkg::DIST_BITS-1:0] out_dist
);

   localparam int VB = nsh_pkg::VEC_BITS;
   localparam int AB = nsh_pkg::ANGLE_BITS;
   localparam int IW = $clog2(CORDIC_STEPS);
   localparam int KW = $clog2(nsh_pkg::NORM_STEPS);

   nsh_pkg::cordic_state_type state_ff, state_in;
   logic signed [VB-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [AB-1:0] z_ff, z_in;
   logic [IW-1:0]        i_ff, i_in;
   logic [KW-1:0]        k_ff, k_in;
   logic                 found_ff, found_in;
   logic [nsh_pkg::DIST_BITS-1:0] dist_ff, dist_in;

   logic signed [VB-1:0] lx, ly, xs, ys;
   logic [VB-1:0]        ay, big;
   logic [6:0]           sh, lim;
   logic signed [AB-1:0] ang, zr;

   assign job_ready = (state_ff == nsh_pkg::CR_IDLE);
   assign lx  = VB'(job_dy);
   assign ly  = VB'(job_dx);
   assign ay  = y_ff[VB-1] ? VB'(-y_ff) : VB'(y_ff);
   assign big = (VB'(x_ff) > ay) ? VB'(x_ff) : ay;
   assign sh  = 7'(1) << (KW'(nsh_pkg::NORM_STEPS - 1) - k_ff);
   assign lim = 7'(nsh_pkg::NORM_TOP) - sh;
   assign xs  = x_ff >>> i_ff;
   assign ys  = y_ff >>> i_ff;
   assign ang = nsh_pkg::atan_q16(5'(i_ff));
   assign zr  = (z_ff + AB'(nsh_pkg::ROUND_HALF)) >>> nsh_pkg::Q7_SHIFT;

   assign out_found = found_ff;
   assign out_dist  = dist_ff;

   always_comb begin
      if (zr > AB'(nsh_pkg::HEAD_MAX)) begin
         out_heading = nsh_pkg::HEAD_BITS'(nsh_pkg::HEAD_MAX);
      end else if (zr < -AB'(nsh_pkg::HEAD_MAX)) begin
         out_heading = nsh_pkg::HEAD_BITS'(-nsh_pkg::HEAD_MAX);
      end else begin
         out_heading = zr[nsh_pkg::HEAD_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      i_in     = i_ff;
      k_in     = k_ff;
      found_in = found_ff;
      dist_in  = dist_ff;
      out_load = 1'b0;
      case (state_ff)
         nsh_pkg::CR_IDLE: begin
            if (job_valid) begin
               found_in = job_found;
               dist_in  = job_dist;
               k_in     = '0;
               i_in     = '0;
               z_in     = '0;
               x_in     = lx;
               y_in     = ly;
               if (lx == '0 && ly == '0) begin
                  state_in = nsh_pkg::CR_DONE;
               end else begin
                  if (lx[VB-1]) begin
                     z_in = ly[VB-1] ? -AB'(nsh_pkg::HALF_TURN) : AB'(nsh_pkg::HALF_TURN);
                     x_in = -lx;
                     y_in = -ly;
                  end
                  state_in = nsh_pkg::CR_NORM;
               end
            end
         end
         nsh_pkg::CR_NORM: begin
            if ((big >> lim) == '0) begin
               x_in = x_ff <<< sh;
               y_in = y_ff <<< sh;
            end
            k_in = k_ff + 1'b1;
            if (k_ff == KW'(nsh_pkg::NORM_STEPS - 1)) begin
               state_in = nsh_pkg::CR_ITER;
            end
         end
         nsh_pkg::CR_ITER: begin
            if (!y_ff[VB-1]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + ang;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - ang;
            end
            i_in = i_ff + 1'b1;
            if (i_ff == IW'(CORDIC_STEPS - 1)) begin
               state_in = nsh_pkg::CR_DONE;
            end
         end
         nsh_pkg::CR_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = nsh_pkg::CR_IDLE;
            end
         end
         default: state_in = nsh_pkg::CR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= nsh_pkg::CR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      i_ff     <= i_in;
      k_ff     <= k_in;
      found_ff <= found_in;
      dist_ff  <= dist_in;
   end

endmodule

[hdl/nsh_checker.sv]
// Port-level checks on the result channel, bound to the top level.
`include "assert_macros.svh"

module nsh_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic signed [nsh_pkg::HEAD_BITS-1:0] rsp_heading_deg,
   input logic                  rsp_found,
   input logic [nsh_pkg::DIST_BITS-1:0] rsp_best_dist_sq
);

   `NSH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `NSH_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_best_dist_sq) && $stable(rsp_heading_deg))
   `NSH_ASSERT_IMPLY(a_empty_result, clock, reset, rsp_valid && !rsp_found, rsp_heading_deg == '0 && rsp_best_dist_sq == '1)
   `NSH_ASSERT_IMPLY(a_heading_range, clock, reset, rsp_valid, rsp_heading_deg <= 16'sd23040 && rsp_heading_deg >= -16'sd23040)

endmodule

bind nearest_segment_heading_core nsh_checker u_nsh_checker (.*);
